[src/assert_macros.svh]
// Assertion helper macros shared by the RTL in this folder.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[src/pcmfs16_pkg.sv]
// Package for the PCM frame to signed 16-bit stereo converter.
// Holds register codes, width codes, the per-channel stage type and
// the sample conversion functions. No dependencies.
package pcmfs16_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_SAMPLE_WIDTH  = 3'd0,
    REG_STEREO        = 3'd1,
    REG_BIG_ENDIAN    = 3'd2,
    REG_FLOAT_SAMPLES = 3'd3,
    REG_DATA_LENGTH   = 3'd4
  } cfg_reg_t;

  // sample width codes
  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;
  localparam logic [1:0] WIDTH_24 = 2'd2;
  localparam logic [1:0] WIDTH_32 = 2'd3;

  localparam logic [15:0] S16_MAX   = 16'd32767;
  localparam logic [7:0]  EXP_ONE   = 8'd127;
  localparam logic [7:0]  EXP_SPECIAL = 8'd255;

  // one channel between the front stage and the result stage
  typedef struct packed {
    logic        flt_path;
    logic [15:0] int_val;
    logic        neg;
    logic        zero;
    logic [7:0]  ex;
    logic [38:0] prod;   // significand * 32767
  } chan_s1_t;

  // Pull one sample word out of the frame, low byte of the word in bits 7:0.
  function automatic logic [31:0] gather_word(logic [63:0] frame, logic [2:0] start,
                                              logic [1:0] wcode, logic be);
    logic [31:0] w;
    logic [2:0]  idx;
    logic [63:0] sh;
    w = '0;
    for (int i = 0; i < 4; i++) begin
      idx = be ? 3'(start + {1'b0, wcode} - 3'(i)) : 3'(start + 3'(i));
      sh  = frame >> {idx, 3'b000};
      if (2'(i) <= wcode) begin
        w[8*i +: 8] = sh[7:0];
      end
    end
    return w;
  endfunction

  // Front half of a channel: integer result, or float fields and the product.
  function automatic chan_s1_t chan_front(logic [31:0] w, logic [1:0] wcode,
                                          logic be, logic flt);
    chan_s1_t    c;
    logic [7:0]  ex;
    logic [22:0] frac;
    logic [23:0] m;
    ex   = w[30:23];
    frac = w[22:0];
    c.flt_path = flt && (wcode == WIDTH_32);
    case (wcode)
      WIDTH_8:  c.int_val = {(be ? w[7] : ~w[7]), w[6:0], 8'h00};
      WIDTH_16: c.int_val = w[15:0];
      WIDTH_24: c.int_val = w[23:8];
      WIDTH_32: c.int_val = w[31:16];
      default:  c.int_val = w[15:0];
    endcase
    c.neg  = w[31];
    // NaN, zero and subnormals all land on 0
    c.zero = ((ex == EXP_SPECIAL) && (frac != '0)) || (ex == '0);
    if ((ex > EXP_ONE) || ((ex == EXP_ONE) && (frac != '0))) begin
      ex   = EXP_ONE;
      frac = '0;
    end
    m      = {1'b1, frac};
    c.ex   = ex;
    c.prod = {m, 15'd0} - {15'd0, m};
    return c;
  endfunction

  // Back half of a float channel: round to 24 bits, truncate, saturate.
  function automatic logic [15:0] float_finish(chan_s1_t c);
    logic [23:0] q_trunc;
    logic        half;
    logic        sticky;
    logic [24:0] q;
    logic [7:0]  sh;
    logic [24:0] mag;
    logic [15:0] mag16;
    if (c.prod[38]) begin
      q_trunc = c.prod[38:15];
      half    = c.prod[14];
      sticky  = |c.prod[13:0];
      sh      = 8'd135 - c.ex;
    end else begin
      q_trunc = c.prod[37:14];
      half    = c.prod[13];
      sticky  = |c.prod[12:0];
      sh      = 8'd136 - c.ex;
    end
    q     = {1'b0, q_trunc} + 25'(half && (sticky || q_trunc[0]));
    mag   = (sh >= 8'd25) ? '0 : (q >> sh[4:0]);
    mag16 = (mag > 25'(S16_MAX)) ? S16_MAX : mag[15:0];
    if (c.zero) begin
      return '0;
    end
    return c.neg ? 16'(-mag16) : mag16;
  endfunction

  function automatic logic [15:0] chan_back(chan_s1_t c);
    return c.flt_path ? float_finish(c) : c.int_val;
  endfunction

endpackage

[src/pcm_frame_to_s16_stereo.sv]
// PCM frame to signed 16-bit stereo converter, top level.
// Pipeline: an accepted input word loads the front register, and its result
// word is then registered in the result register.
// Throughput: one frame per cycle; a stall moves back from the result register.
// Reset (rst, sync, active high): pipeline empty, byte count and end flag
// cleared, config back to 16-bit stereo little-endian integer, length 0.
module pcm_frame_to_s16_stereo (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // frame input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] frame_bytes,
  // result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] left_sample,
  output logic signed [15:0] right_sample,
  output logic        frame_valid
);
  import pcmfs16_pkg::*;
  `include "assert_macros.svh"

  // config registers
  logic [1:0]  sample_width_code;
  logic        stereo;
  logic        big_endian;
  logic        float_samples;
  logic [31:0] data_length;

  // stream accounting
  logic [31:0] consumed_bytes;
  logic        stream_ended;

  // front stage register
  logic     s1_valid;
  logic     s1_ok;
  chan_s1_t s1_left;
  chan_s1_t s1_right;

  logic     in_fire;
  logic     s1_adv;
  logic [3:0]  bpf;
  logic [32:0] bytes_after;
  logic        past_end;
  logic [2:0]  right_start;
  chan_s1_t    front_left;
  chan_s1_t    front_right;

  // config port never stalls; writes must come only while idle, which the block does not enforce
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_width_code <= WIDTH_16;
      stereo            <= 1'b1;
      big_endian        <= 1'b0;
      float_samples     <= 1'b0;
      data_length       <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLE_WIDTH:  sample_width_code <= cfg_data[1:0];
        REG_STEREO:        stereo            <= cfg_data[0];
        REG_BIG_ENDIAN:    big_endian        <= cfg_data[0];
        REG_FLOAT_SAMPLES: float_samples     <= cfg_data[0];
        REG_DATA_LENGTH:   data_length       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: front register moves on when the result register is free
  // or being drained; input is taken when the front register is free or moving.
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // bytes per frame = bytes per sample (1..4), doubled for stereo
  assign bpf         = {1'b0, {1'b0, sample_width_code} + 3'd1} << stereo;
  assign bytes_after = {1'b0, consumed_bytes} + {29'd0, bpf};
  assign past_end    = stream_ended || (bytes_after > {1'b0, data_length});

  // Once past the end the flag sticks; the count freezes.
  always_ff @(posedge clk) begin
    if (rst) begin
      consumed_bytes <= '0;
      stream_ended   <= 1'b0;
    end else if (in_fire) begin
      if (past_end) begin
        stream_ended <= 1'b1;
      end else begin
        consumed_bytes <= bytes_after[31:0];
      end
    end
  end

  // front half: byte gather, integer form, float product
  assign right_start = {1'b0, sample_width_code} + 3'd1;
  assign front_left  = chan_front(gather_word(frame_bytes, 3'd0, sample_width_code, big_endian),
                                  sample_width_code, big_endian, float_samples);
  assign front_right = chan_front(gather_word(frame_bytes, right_start, sample_width_code,
                                              big_endian),
                                  sample_width_code, big_endian, float_samples);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ok    <= !past_end;
      s1_left  <= front_left;
      s1_right <= stereo ? front_right : front_left;  // mono copies left
    end
  end

  // back half: rounding, scaling and saturation into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid) begin
      frame_valid  <= s1_ok;
      left_sample  <= s1_ok ? chan_back(s1_left) : '0;
      right_sample <= s1_ok ? chan_back(s1_right) : '0;
    end
  end

  // checks
  `ASSERT_CLK(a_end_sticky, stream_ended |=> stream_ended,
              "stream end flag dropped without reset")
  `ASSERT_CLK(a_invalid_zero,
              (out_valid && !frame_valid) |-> (left_sample == '0 && right_sample == '0),
              "invalid frame carries nonzero samples")
  `ASSERT_CLK(a_count_step, (in_fire && !past_end) |=>
              (consumed_bytes == $past(bytes_after[31:0])),
              "byte count did not advance by frame size")
  `ASSERT_CLK(a_s1_hold, (s1_valid && !s1_adv) |=> s1_valid,
              "front stage word lost during stall")
  `ASSERT_ALWAYS(a_reset_empty, rst |=> (!out_valid && !s1_valid),
                 "pipeline not empty after reset")

endmodule
